@@ rtl/flr_pkg.sv @@
// Shared constants and types for the framebuffer line rasterizer.
package flr_pkg;

  // Field widths fixed by the request and result formats
  localparam int COORD_W = 6;
  localparam int MODE_W  = 2;
  localparam int BANK_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int ERR_W   = 10;

  // Pixel modes; the unused code behaves as clear
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd2;

  // One finished pixel write waiting for delivery
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [BANK_W-1:0]  bank;
    logic [BYTE_W-1:0]  byte_value;
  } result_t;

endpackage

@@ rtl/flr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module flr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents before a write at the same edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/framebuffer_line_raster.sv @@
// Top level: Bresenham line walker with read-modify-write of a banked frame store.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | request   | in_valid / in_stall  | x_start y_start x_end y_end pixel_mode
//  out     | result    | out_valid / out_stall| column bank byte_value last
//
// A line walks one pixel per cycle through the single frame store read port;
// a stalled output freezes the whole walk. The next request is taken only once
// the walk, the modify stage and the held-back result have drained. The last
// result is held back one pixel so its last flag is known. After reset a clearing
// pass writes BANKS*COLUMNS zero bytes, one per cycle, with in_stall high.
module framebuffer_line_raster #(
  parameter int COLUMNS = 64,
  parameter int BANKS   = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [flr_pkg::COORD_W-1:0]  x_start,
  input  logic [flr_pkg::COORD_W-1:0]  y_start,
  input  logic [flr_pkg::COORD_W-1:0]  x_end,
  input  logic [flr_pkg::COORD_W-1:0]  y_end,
  input  logic [flr_pkg::MODE_W-1:0]   pixel_mode,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [flr_pkg::COORD_W-1:0]  column,
  output logic [flr_pkg::BANK_W-1:0]   bank,
  output logic [flr_pkg::BYTE_W-1:0]   byte_value,
  output logic                         last
);

  import flr_pkg::*;

  localparam int ROWS   = BANKS * 8;
  localparam int DEPTH  = BANKS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Line registers
  logic                       busy;
  logic [COORD_W-1:0]         x, y, xe, ye;
  logic                       sx_neg, sy_neg, x_major;
  logic [COORD_W:0]           dx2, dy2;
  logic signed [ERR_W-1:0]    err;
  logic [MODE_W-1:0]          mode;

  // Clearing pass
  logic                       clr_busy;
  logic [ADDR_W-1:0]          clr_addr;

  // Modify stage and forwarding
  logic                       s2_valid;
  logic [ADDR_W-1:0]          s2_addr;
  logic [2:0]                 s2_bit;
  logic [COORD_W-1:0]         s2_col;
  logic [BANK_W-1:0]          s2_bank;
  logic                       fwd_valid;
  logic [ADDR_W-1:0]          fwd_addr;
  logic [BYTE_W-1:0]          fwd_data;

  // Held-back result and output register
  logic                       pend_valid;
  result_t                    pend;

  logic                       in_accept, adv, on_screen, at_end, rd_en, wr_en;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic [BYTE_W-1:0]          rd_data, old_byte, new_byte, mask, wr_data;
  logic [COORD_W:0]           ddx, ddy;
  logic [COORD_W-1:0]         adx, ady;
  logic [COORD_W:0]           in_dx2, in_dy2;
  logic                       in_x_major;
  logic signed [ERR_W-1:0]    err_sub, err_next;
  logic                       minor_step;
  logic [COORD_W-1:0]         x_next, y_next;

  assign in_stall  = busy | s2_valid | pend_valid | clr_busy;
  assign in_accept = in_valid & ~in_stall;
  assign adv       = ~out_valid | ~out_stall;

  // Differences of a new request
  always_comb begin
    ddx        = {1'b0, x_end} - {1'b0, x_start};
    ddy        = {1'b0, y_end} - {1'b0, y_start};
    adx        = ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
    ady        = ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
    in_dx2     = {adx, 1'b0};
    in_dy2     = {ady, 1'b0};
    in_x_major = in_dx2 > in_dy2;
  end

  // One Bresenham step from the current point
  always_comb begin
    logic [COORD_W:0] maj2, min2;
    maj2       = x_major ? dx2 : dy2;
    min2       = x_major ? dy2 : dx2;
    minor_step = ~err[ERR_W-1];
    err_sub    = minor_step ? err - ERR_W'(maj2) : err;
    err_next   = err_sub + ERR_W'(min2);
    x_next     = x;
    y_next     = y;
    if (x_major || minor_step) begin
      x_next = sx_neg ? x - COORD_W'(1) : x + COORD_W'(1);
    end
    if (!x_major || minor_step) begin
      y_next = sy_neg ? y - COORD_W'(1) : y + COORD_W'(1);
    end
    at_end = x_major ? (x == xe) : (y == ye);
  end

  // Current point visibility and frame address
  always_comb begin
    on_screen = (int'(x) < COLUMNS) && (int'(y) < ROWS);
    rd_addr   = ADDR_W'(int'(y[COORD_W-1:3]) * COLUMNS + int'(x));
    rd_en     = adv & busy & on_screen;
  end

  // Walker
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_accept) begin
      busy <= 1'b1;
    end else if (busy && adv && at_end) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x       <= x_start;
      y       <= y_start;
      xe      <= x_end;
      ye      <= y_end;
      sx_neg  <= ddx[COORD_W];
      sy_neg  <= ddy[COORD_W];
      dx2     <= in_dx2;
      dy2     <= in_dy2;
      x_major <= in_x_major;
      mode    <= pixel_mode;
      err     <= in_x_major ? ERR_W'(in_dy2) - ERR_W'(adx) : ERR_W'(in_dx2) - ERR_W'(ady);
    end else if (busy && adv && !at_end) begin
      x   <= x_next;
      y   <= y_next;
      err <= err_next;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Modify stage: take the byte, forwarding the write of the previous step
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= busy & on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_addr <= rd_addr;
      s2_bit  <= y[2:0];
      s2_col  <= x;
      s2_bank <= y[COORD_W-1:3];
    end
  end

  always_comb begin
    old_byte = (fwd_valid && fwd_addr == s2_addr) ? fwd_data : rd_data;
    mask     = BYTE_W'(1) << s2_bit;
    case (mode)
      MODE_SET:    new_byte = old_byte | mask;
      MODE_TOGGLE: new_byte = old_byte ^ mask;
      default:     new_byte = old_byte & ~mask;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      fwd_addr <= s2_addr;
      fwd_data <= new_byte;
    end
  end

  // Store write port: clearing pass or pixel write-back
  always_comb begin
    wr_en   = clr_busy | (adv & s2_valid);
    wr_addr = clr_busy ? clr_addr : s2_addr;
    wr_data = clr_busy ? '0 : new_byte;
  end

  flr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Hold one result back; release it when the next arrives or the line ends
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      if (s2_valid) begin
        pend_valid <= 1'b1;
        out_valid  <= pend_valid;
      end else if (pend_valid && !busy) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      pend.column     <= s2_col;
      pend.bank       <= s2_bank;
      pend.byte_value <= new_byte;
      if (pend_valid) begin
        column     <= pend.column;
        bank       <= pend.bank;
        byte_value <= pend.byte_value;
        last       <= 1'b0;
      end
    end else if (adv && pend_valid && !busy) begin
      column     <= pend.column;
      bank       <= pend.bank;
      byte_value <= pend.byte_value;
      last       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // No pixel work while the store is being cleared
  a_no_pixel_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s2_valid && !busy)
    else $error("pixel access during clearing pass");

  // A new line starts only with the previous one fully drained
  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !pend_valid && !s2_valid && !busy)
    else $error("request accepted while a line is still in flight");

  // End of walk releases the held result marked last
  a_last_release: assert property (@(posedge clk) disable iff (rst)
    (adv && pend_valid && !s2_valid && !busy) |=> (out_valid && last))
    else $error("final result not flagged last");

  // Forwarded byte always comes from the write of the step just before
  a_fwd_follows_write: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid) |=> fwd_valid)
    else $error("forwarding register not loaded after write-back");
`endif

endmodule
